### hw/rtl/wtrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtrl_pkg
// Shared constants for the window and token rate limiter: default widths, the
// refill period, request type codes, register indexes, register reset values.
// ----------------------------------------------------------------------------
package wtrl_pkg;

  // default widths of timestamps and counters
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // one token is credited per refill period
  localparam int REFILL_MS   = 1000;
  localparam int REFILL_BITS = $clog2(REFILL_MS);

  // request type codes
  localparam logic [1:0] REQ_ADMIT = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MAX_REQ    = 2'd0;
  localparam logic [1:0] REG_WINDOW_LEN = 2'd1;
  localparam logic [1:0] REG_BURST      = 2'd2;

  // register reset values
  localparam int MAX_REQ_RST    = 16;
  localparam int WINDOW_LEN_RST = 1000;
  localparam int BURST_RST      = 16;

endpackage

### hw/rtl/window_and_token_rate_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_and_token_rate_limiter_unit
// Each item passes through the input register, then the result register, and
// the result is offered from the result register. Throughput: one item per
// cycle while the result side does not stall; the limiter state feeds back
// through one pass of logic (window compare, refill multiply by the reciprocal
// of 1000, grant) and updates as the item leaves the input register. Reset
// (rst_n low, synchronous) empties both registers, restarts the window at time 0
// and fills the bucket to the reset burst size.
// ----------------------------------------------------------------------------
module window_and_token_rate_limiter_unit
  import wtrl_pkg::*;
#(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  localparam int CFG_DW     = (TIME_WIDTH > 32 || COUNT_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB   = (CFG_DW > 32) ? 3 : 2,
  localparam int CFG_AW     = ADDR_LSB + 2
) (
  input  logic                   clk,
  input  logic                   rst_n,

  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_req_type,
  input  logic [TIME_WIDTH-1:0]  in_now_ms,

  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_granted,
  output logic [TIME_WIDTH-1:0]  out_window_remaining_ms,
  output logic [COUNT_WIDTH-1:0] out_window_count,
  output logic [COUNT_WIDTH-1:0] out_tokens_left,

  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_AW-1:0]      paddr,
  input  logic [CFG_DW-1:0]      pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // quotient operand width: large enough to cover every credit below the burst
  localparam int QW     = COUNT_WIDTH + REFILL_BITS;
  localparam int SHIFT  = QW + REFILL_BITS;
  localparam int PW     = 2 * QW + 1;
  localparam int CMP_W  = (TIME_WIDTH > QW) ? TIME_WIDTH : QW;
  localparam logic [QW:0] RECIP =
    (QW + 1)'(((64'd1 << SHIFT) / 64'(REFILL_MS)) + 64'd1);

  // configuration registers
  logic [COUNT_WIDTH-1:0] max_req_r;
  logic [TIME_WIDTH-1:0]  win_len_r;
  logic [COUNT_WIDTH-1:0] burst_r;

  // limiter state
  logic [TIME_WIDTH-1:0]  win_start_r, win_start_nxt;
  logic [COUNT_WIDTH-1:0] req_cnt_r, req_cnt_nxt;
  logic [COUNT_WIDTH-1:0] tok_r, tok_nxt;
  logic [TIME_WIDTH-1:0]  refill_r, refill_nxt;

  // input register
  logic                   s1_v_r;
  logic [1:0]             s1_type_r;
  logic [TIME_WIDTH-1:0]  s1_now_r;

  // result register
  logic                   out_v_r;
  logic                   granted_r, granted_nxt;
  logic [TIME_WIDTH-1:0]  remain_r, remain_nxt;
  logic [COUNT_WIDTH-1:0] cnt_out_r;
  logic [COUNT_WIDTH-1:0] tok_out_r;

  logic                   out_free;
  logic                   s1_adv;
  logic                   in_xfer;
  logic                   cfg_wr;
  logic [1:0]             cfg_idx;

  // datapath signals
  logic                   is_admit, is_reset;
  logic [TIME_WIDTH-1:0]  el_win;
  logic                   expired;
  logic                   restart;
  logic [TIME_WIDTH-1:0]  since_refill;
  logic                   refill_due;
  logic [CMP_W-1:0]       since_ext;
  logic [COUNT_WIDTH-1:0] room;
  logic [QW-1:0]          room_ms;
  logic [PW-1:0]          prod;
  logic [COUNT_WIDTH-1:0] credit;
  logic                   fill_up;
  logic [COUNT_WIDTH-1:0] tok_ref;
  logic [COUNT_WIDTH-1:0] cnt_eff;

  // handshake
  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // configuration decode
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:ADDR_LSB];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MAX_REQ:    prdata = CFG_DW'(max_req_r);
      REG_WINDOW_LEN: prdata = CFG_DW'(win_len_r);
      REG_BURST:      prdata = CFG_DW'(burst_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= COUNT_WIDTH'(MAX_REQ_RST);
      win_len_r <= TIME_WIDTH'(WINDOW_LEN_RST);
      burst_r   <= COUNT_WIDTH'(BURST_RST);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MAX_REQ:    max_req_r <= pwdata[COUNT_WIDTH-1:0];
        REG_WINDOW_LEN: win_len_r <= pwdata[TIME_WIDTH-1:0];
        REG_BURST:      burst_r   <= pwdata[COUNT_WIDTH-1:0];
        default:        ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_type_r <= in_req_type;
      s1_now_r  <= in_now_ms;
    end
  end

  // request decode, unused code acts as a query
  always_comb begin
    is_admit = 1'b0;
    is_reset = 1'b0;
    case (s1_type_r)
      REQ_ADMIT: is_admit = 1'b1;
      REQ_RESET: is_reset = 1'b1;
      default:   ;
    endcase
  end

  // window expiry, elapsed time wraps with the timestamp
  assign el_win  = s1_now_r - win_start_r;
  assign expired = el_win >= win_len_r;
  assign restart = (is_admit && expired) || is_reset;

  // refill: credit = since_refill / 1000 by reciprocal multiply
  assign since_refill = s1_now_r - refill_r;
  assign refill_due   = since_refill >= TIME_WIDTH'(REFILL_MS);
  assign since_ext    = CMP_W'(since_refill);
  assign room         = burst_r - tok_r;
  assign room_ms      = QW'(room) * QW'(REFILL_MS);
  assign prod         = PW'(since_ext[QW-1:0]) * PW'(RECIP);
  assign credit       = prod[SHIFT +: COUNT_WIDTH];
  // bucket reaches capacity when already full or credit covers the room
  assign fill_up      = (tok_r >= burst_r) || (since_ext >= CMP_W'(room_ms));

  always_comb begin
    tok_ref = tok_r;
    if (refill_due) begin
      tok_ref = fill_up ? burst_r : tok_r + credit;
    end
  end

  assign cnt_eff = expired ? '0 : req_cnt_r;

  // next state and result
  always_comb begin
    win_start_nxt = win_start_r;
    req_cnt_nxt   = req_cnt_r;
    tok_nxt       = tok_r;
    refill_nxt    = refill_r;
    granted_nxt   = 1'b0;
    if (is_admit) begin
      if (expired) begin
        win_start_nxt = s1_now_r;
      end
      if (refill_due) begin
        refill_nxt = s1_now_r;
      end
      req_cnt_nxt = cnt_eff;
      tok_nxt     = tok_ref;
      if (cnt_eff < max_req_r && tok_ref != '0) begin
        granted_nxt = 1'b1;
        req_cnt_nxt = cnt_eff + COUNT_WIDTH'(1);
        tok_nxt     = tok_ref - COUNT_WIDTH'(1);
      end
    end else if (is_reset) begin
      win_start_nxt = s1_now_r;
      req_cnt_nxt   = '0;
      tok_nxt       = burst_r;
      refill_nxt    = s1_now_r;
    end
  end

  // a restarted window has its full length left
  always_comb begin
    if (restart) begin
      remain_nxt = win_len_r;
    end else if (expired) begin
      remain_nxt = '0;
    end else begin
      remain_nxt = win_len_r - el_win;
    end
  end

  // state update as the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_start_r <= '0;
      req_cnt_r   <= '0;
      tok_r       <= COUNT_WIDTH'(BURST_RST);
      refill_r    <= '0;
    end else if (s1_adv) begin
      win_start_r <= win_start_nxt;
      req_cnt_r   <= req_cnt_nxt;
      tok_r       <= tok_nxt;
      refill_r    <= refill_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      granted_r <= granted_nxt;
      remain_r  <= remain_nxt;
      cnt_out_r <= req_cnt_nxt;
      tok_out_r <= tok_nxt;
    end
  end

  assign out_valid               = out_v_r;
  assign out_granted             = granted_r;
  assign out_window_remaining_ms = remain_r;
  assign out_window_count        = cnt_out_r;
  assign out_tokens_left         = tok_out_r;

endmodule

### verif/wtrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtrl_checker
// Watches the input, result and configuration ports of the window and token
// rate limiter. Keeps its own copy of the limiter state and registers, works
// out the decision for every input transfer, and compares every result
// transfer and every mapped register read against it. Hands the mismatch
// count and the number of decisions still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module wtrl_checker
  import wtrl_pkg::*;
#(
  parameter int TW = TIME_WIDTH_DEF,
  parameter int CW = COUNT_WIDTH_DEF,
  parameter int DW = 32,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,

  input  logic          in_valid,
  input  logic          in_stall,
  input  logic [1:0]    in_req_type,
  input  logic [TW-1:0] in_now_ms,

  input  logic          out_valid,
  input  logic          out_stall,
  input  logic          out_granted,
  input  logic [TW-1:0] out_window_remaining_ms,
  input  logic [CW-1:0] out_window_count,
  input  logic [CW-1:0] out_tokens_left,

  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [DW-1:0] pwdata,
  input  logic [DW-1:0] prdata,
  input  logic          pready,

  output int            mismatch_count,
  output int            results_due
);

  typedef struct packed {
    logic          granted;
    logic [TW-1:0] remaining_ms;
    logic [CW-1:0] window_count;
    logic [CW-1:0] tokens_left;
  } decision_t;

  // register copies
  logic [CW-1:0] cfg_max_req;
  logic [TW-1:0] cfg_window_len;
  logic [CW-1:0] cfg_burst;

  // limiter state copies
  logic [TW-1:0] win_start;
  logic [CW-1:0] req_count;
  logic [CW-1:0] tokens;
  logic [TW-1:0] last_refill;

  decision_t decisions_due[$];

  // one decision per item, updating the limiter state as the block does
  function automatic decision_t decide_request(input logic [1:0] kind,
                                               input logic [TW-1:0] now);
    logic [TW-1:0] since_win;
    logic [TW-1:0] since_refill;
    logic [TW-1:0] credit;
    logic [TW-1:0] room;
    decision_t     d;
    d = '0;
    case (kind)
      REQ_ADMIT: begin
        // restart an expired window
        since_win = now - win_start;
        if (since_win >= cfg_window_len) begin
          win_start = now;
          req_count = '0;
        end
        // whole seconds since the last refill turn into tokens
        since_refill = now - last_refill;
        if (since_refill >= TW'(REFILL_MS)) begin
          credit = since_refill / TW'(REFILL_MS);
          room   = (tokens < cfg_burst) ? TW'(cfg_burst - tokens) : '0;
          if (tokens > cfg_burst || credit >= room) begin
            tokens = cfg_burst;
          end else begin
            tokens = tokens + credit[CW-1:0];
          end
          last_refill = now;
        end
        // both limits must allow it
        if (req_count < cfg_max_req && tokens != '0) begin
          req_count = req_count + CW'(1);
          tokens    = tokens - CW'(1);
          d.granted = 1'b1;
        end
      end
      REQ_RESET: begin
        req_count   = '0;
        win_start   = now;
        tokens      = cfg_burst;
        last_refill = now;
      end
      default: ;
    endcase
    since_win      = now - win_start;
    d.remaining_ms = (since_win < cfg_window_len) ? cfg_window_len - since_win : '0;
    d.window_count = req_count;
    d.tokens_left  = tokens;
    return d;
  endfunction

  always @(posedge clk) begin : watch
    decision_t     seen;
    decision_t     due;
    logic [DW-1:0] reg_value;
    logic          known_reg;
    if (!rst_n) begin
      cfg_max_req    = CW'(MAX_REQ_RST);
      cfg_window_len = TW'(WINDOW_LEN_RST);
      cfg_burst      = CW'(BURST_RST);
      win_start      = '0;
      req_count      = '0;
      tokens         = CW'(BURST_RST);
      last_refill    = '0;
      decisions_due.delete();
    end else begin
      // register accesses
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[AW-1:AW-2])
            REG_MAX_REQ:    cfg_max_req    = pwdata[CW-1:0];
            REG_WINDOW_LEN: cfg_window_len = pwdata[TW-1:0];
            REG_BURST:      cfg_burst      = pwdata[CW-1:0];
            default: ;
          endcase
        end else begin
          known_reg = 1'b1;
          reg_value = '0;
          case (paddr[AW-1:AW-2])
            REG_MAX_REQ:    reg_value[CW-1:0] = cfg_max_req;
            REG_WINDOW_LEN: reg_value[TW-1:0] = cfg_window_len;
            REG_BURST:      reg_value[CW-1:0] = cfg_burst;
            default:        known_reg = 1'b0;
          endcase
          if (known_reg && prdata !== reg_value) begin
            if (mismatch_count < 10)
              $display("register read mismatch at %0h: expected %0h, got %0h",
                       paddr, reg_value, prdata);
            mismatch_count++;
          end
        end
      end

      // result transfers
      if (out_valid && !out_stall) begin
        seen.granted      = out_granted;
        seen.remaining_ms = out_window_remaining_ms;
        seen.window_count = out_window_count;
        seen.tokens_left  = out_tokens_left;
        if (decisions_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("result with nothing expected: granted=%0d remaining=%0d count=%0d tokens=%0d",
                     seen.granted, seen.remaining_ms, seen.window_count, seen.tokens_left);
          mismatch_count++;
        end else begin
          due = decisions_due.pop_front();
          if (seen.granted !== due.granted || seen.remaining_ms !== due.remaining_ms ||
              seen.window_count !== due.window_count ||
              seen.tokens_left !== due.tokens_left) begin
            if (mismatch_count < 10) begin
              $display("result mismatch: expected granted=%0d remaining=%0d count=%0d tokens=%0d",
                       due.granted, due.remaining_ms, due.window_count, due.tokens_left);
              $display("                 actual   granted=%0d remaining=%0d count=%0d tokens=%0d",
                       seen.granted, seen.remaining_ms, seen.window_count, seen.tokens_left);
            end
            mismatch_count++;
          end
        end
      end

      // input transfers
      if (in_valid && !in_stall)
        decisions_due.push_back(decide_request(in_req_type, in_now_ms));
    end
    results_due <= decisions_due.size();
  end

endmodule

### verif/tb_window_and_token_rate_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_and_token_rate_limiter_unit
// Drives admission, reset and query items into the rate limiter under a
// series of register settings, starting with a directed pass over the edge
// cases and then random traffic with random gaps and result stalls, one long
// result hold-off and one stretch without any idling. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_window_and_token_rate_limiter_unit;
  import wtrl_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;
  localparam int CW = COUNT_WIDTH_DEF;
  localparam int DW = 32;
  localparam int AW = 4;

  // unused request type, handled as a query
  localparam logic [1:0] REQ_SPARE = 2'd3;
  // register slot past the end of the map
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;

  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_req_type = REQ_QUERY;
  logic [TW-1:0] in_now_ms = '0;

  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_granted;
  logic [TW-1:0] out_window_remaining_ms;
  logic [CW-1:0] out_window_count;
  logic [CW-1:0] out_tokens_left;

  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic          pready;

  int            mismatch_count;
  int            results_due;
  int            cycle_count = 0;

  logic          calm = 1'b0;
  logic          pressure_on = 1'b0;
  logic          pressure_served = 1'b0;
  int            hold_left = 0;
  logic [TW-1:0] clock_ms = '0;

  always #10 clk = ~clk;

  window_and_token_rate_limiter_unit u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_req_type             (in_req_type),
    .in_now_ms               (in_now_ms),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_granted             (out_granted),
    .out_window_remaining_ms (out_window_remaining_ms),
    .out_window_count        (out_window_count),
    .out_tokens_left         (out_tokens_left),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  wtrl_checker #(.TW(TW), .CW(CW), .DW(DW), .AW(AW)) u_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_req_type             (in_req_type),
    .in_now_ms               (in_now_ms),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_granted             (out_granted),
    .out_window_remaining_ms (out_window_remaining_ms),
    .out_window_count        (out_window_count),
    .out_tokens_left         (out_tokens_left),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready),
    .mismatch_count          (mismatch_count),
    .results_due             (results_due)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_window_and_token_rate_limiter_unit: FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off when asked for
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_on && !pressure_served) begin
      out_stall       <= 1'b1;
      hold_left       <= HOLD_OFF_CYCLES - 1;
      pressure_served <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 33);
      if (!pressure_on)
        pressure_served <= 1'b0;
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic offer_item(input logic [1:0] kind, input logic [TW-1:0] stamp);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_now_ms   <= stamp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering and wait until every decision has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // setup and access cycle on the register port
  task automatic reg_access(input logic write, input logic [1:0] index,
                            input logic [DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {index, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // new register settings once the block is idle, then read them back
  task automatic reprogram(input logic [CW-1:0] max_req, input logic [TW-1:0] window_len,
                           input logic [CW-1:0] burst);
    logic [15:0] junk;
    drain_results();
    junk = 16'($urandom);
    reg_access(1'b1, REG_MAX_REQ, {junk, max_req});
    reg_access(1'b1, REG_WINDOW_LEN, window_len);
    junk = 16'($urandom);
    reg_access(1'b1, REG_BURST, {junk, burst});
    reg_access(1'b0, REG_MAX_REQ, '0);
    reg_access(1'b0, REG_WINDOW_LEN, '0);
    reg_access(1'b0, REG_BURST, '0);
  endtask

  // random traffic: mostly admissions at a steady pace, some jumps and wraps
  task automatic run_traffic(input int count);
    logic [1:0] kind;
    int         roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 70)      kind = REQ_ADMIT;
      else if (roll < 80) kind = REQ_RESET;
      else if (roll < 95) kind = REQ_QUERY;
      else                kind = REQ_SPARE;
      roll = $urandom_range(0, 99);
      if (roll < 50)      clock_ms = clock_ms + $urandom_range(0, 50);
      else if (roll < 80) clock_ms = clock_ms + $urandom_range(0, 600);
      else if (roll < 93) clock_ms = clock_ms + $urandom_range(900, 3500);
      else if (roll < 97) clock_ms = $urandom;
      else                clock_ms = clock_ms - $urandom_range(1, 2000);
      offer_item(kind, clock_ms);
    end
  endtask

  initial begin : stimulus
    logic [CW-1:0] max_req;
    logic [TW-1:0] window_len;
    logic [CW-1:0] burst;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: window restart, refill steps, query, spare type, wrap
    offer_item(REQ_ADMIT, 32'd0);
    offer_item(REQ_QUERY, 32'd500);
    offer_item(REQ_SPARE, 32'd600);
    offer_item(REQ_ADMIT, 32'd999);
    offer_item(REQ_ADMIT, 32'd1000);
    offer_item(REQ_ADMIT, 32'd3999);
    offer_item(REQ_QUERY, 32'd5000);
    offer_item(REQ_RESET, 32'hFFFF_FF00);
    offer_item(REQ_ADMIT, 32'h0000_0100);
    offer_item(REQ_ADMIT, 32'hFFFF_FFFF);
    offer_item(REQ_ADMIT, 32'h8000_0000);

    // zero window length with a tiny bucket
    reprogram(16'd2, 32'd0, 16'd3);
    offer_item(REQ_ADMIT, 32'd10);
    offer_item(REQ_ADMIT, 32'd10);
    offer_item(REQ_ADMIT, 32'd10);
    offer_item(REQ_ADMIT, 32'd10);
    offer_item(REQ_RESET, 32'd20);

    // zero limits
    reprogram(16'd0, 32'hFFFF_FFFF, 16'd0);
    offer_item(REQ_RESET, 32'd30);
    offer_item(REQ_ADMIT, 32'd40);
    offer_item(REQ_ADMIT, 32'd5000);

    // widest limits, a write past the map, then a lowered bucket
    reprogram(16'hFFFF, 32'd1, 16'hFFFF);
    reg_access(1'b1, REG_SPARE, 32'hFFFF_FFFF);
    offer_item(REQ_RESET, 32'd100);
    offer_item(REQ_ADMIT, 32'd101);
    reprogram(16'hFFFF, 32'd1, 16'd4);
    offer_item(REQ_ADMIT, 32'd102);
    offer_item(REQ_ADMIT, 32'd1200);

    // random phases under a spread of settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: reprogram(16'd16, 32'd1000, 16'd16);
        1: reprogram(16'd1, 32'd1, 16'd1);
        2: reprogram(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        3: reprogram(16'd0, 32'd0, 16'd0);
        4: reprogram(16'd3, 32'd500, 16'd4);
        5: reprogram(16'd8, 32'd2000, 16'd8);
        6: reprogram(16'd5, 32'd0, 16'd2);
        default: begin
          max_req    = CW'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40));
          window_len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 5000);
          burst      = CW'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40));
          reprogram(max_req, window_len, burst);
        end
      endcase
      calm        <= (p == 4);
      pressure_on <= (p == 5);
      if (p % 3 == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
      else            clock_ms = $urandom;
      run_traffic(ITEMS_PER_PHASE);
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb_window_and_token_rate_limiter_unit: PASS");
    end else begin
      $display("tb_window_and_token_rate_limiter_unit: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/wtrl_pkg.sv
hw/rtl/window_and_token_rate_limiter_unit.sv
verif/wtrl_checker.sv
verif/tb_window_and_token_rate_limiter_unit.sv
